FILE: hw/rtl/vic_pkg.sv
// vic_pkg: shared types and constants for the vectored interrupt controller.
// Holds the request/response item structs, command codes and the register map.
// No dependencies.
package vic_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_NUM_SLOTS   = 16;
  localparam int DEF_NUM_SOURCES = 32;

  // bus commands (code 3 behaves as sample only)
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  // register map, in 32-bit words
  localparam logic [7:0] OFS_STATUS  = 8'h00;
  localparam logic [7:0] OFS_ENSET   = 8'h04;
  localparam logic [7:0] OFS_ENCLR   = 8'h05;
  localparam logic [7:0] OFS_VECTOR  = 8'h0C;
  localparam logic [7:0] OFS_DEFVEC  = 8'h0D;
  localparam logic [7:0] OFS_SLOTVEC = 8'h40;
  localparam logic [7:0] OFS_SLOTCTL = 8'h80;

  // slot control word: source id in the low bits, enable on top
  localparam int CTL_W       = 6;
  localparam int CTL_SRC_W   = 5;
  localparam int CTL_EN_BIT  = 5;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  word_index;
    logic [31:0] write_data;
    logic [31:0] raw_sources;
  } vic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        vector_hit;
  } vic_out_t;

endpackage

FILE: hw/rtl/vic_pick.sv
// vic_pick: fixed-priority slot match, lowest slot number wins.
// Depends on vic_pkg for the control word layout.
module vic_pick import vic_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic [31:0]                       status,
  input  logic [NUM_SLOTS-1:0][CTL_W-1:0]   ctl,
  output logic                              hit,
  output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] slot
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0] match;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = ctl[i][CTL_EN_BIT] && status[ctl[i][CTL_SRC_W-1:0]];
    end
  end

  // priority encode, low index has precedence
  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        slot = SlotW'(i);
      end
    end
  end

  assign hit = |match;

endmodule

FILE: hw/rtl/vic_regs.sv
// vic_regs: controller state, register decode, read mux and slot pick.
// Depends on vic_pkg and vic_pick.
module vic_regs import vic_pkg::*; #(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  vic_in_t     item,
  output logic [31:0] read_data,
  output logic        irq_request,
  output logic        vector_hit
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [5:0] NumSlots6 = 6'(NUM_SLOTS);

  logic [NUM_SOURCES-1:0]          enable_mask;
  logic [NUM_SOURCES-1:0]          enable_mask_next;
  logic [31:0]                     default_vector;
  logic [31:0]                     slot_vector [NUM_SLOTS];
  logic [NUM_SLOTS-1:0][CTL_W-1:0] slot_control;
  logic [NUM_SLOTS-1:0][CTL_W-1:0] slot_control_next;

  logic [NUM_SOURCES-1:0] raw;
  logic [NUM_SOURCES-1:0] status_cur;
  logic [NUM_SOURCES-1:0] status_next;
  logic                   is_read;
  logic                   is_write;
  logic                   in_slot_vec;
  logic                   in_slot_ctl;
  logic [SlotW-1:0]       slot_addr;
  logic [SlotW-1:0]       rd_addr;
  logic [31:0]            rd_slot_vec;
  logic                   hit_cur;
  logic [SlotW-1:0]       slot_cur;
  logic                   hit_next;
  logic [SlotW-1:0]       slot_next;

  assign raw        = item.raw_sources[NUM_SOURCES-1:0];
  assign status_cur = raw & enable_mask;

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    case (item.command)
      CMD_READ:  is_read  = 1'b1;
      CMD_WRITE: is_write = 1'b1;
      default:   ; // CMD_SAMPLE and the reserved code
    endcase
  end

  assign in_slot_vec = (item.word_index[7:6] == OFS_SLOTVEC[7:6]) &&
                       (item.word_index[5:0] < NumSlots6);
  assign in_slot_ctl = (item.word_index[7:6] == OFS_SLOTCTL[7:6]) &&
                       (item.word_index[5:0] < NumSlots6);
  assign slot_addr   = item.word_index[SlotW-1:0];

  // state after this item's write
  always_comb begin
    enable_mask_next  = enable_mask;
    slot_control_next = slot_control;
    if (is_write) begin
      case (item.word_index)
        OFS_ENSET: enable_mask_next = enable_mask | item.write_data[NUM_SOURCES-1:0];
        OFS_ENCLR: enable_mask_next = enable_mask & ~item.write_data[NUM_SOURCES-1:0];
        default: begin
          if (in_slot_ctl) begin
            slot_control_next[slot_addr] = item.write_data[CTL_W-1:0];
          end
        end
      endcase
    end
  end

  assign status_next = raw & enable_mask_next;

  // pick on current state for vector reads
  vic_pick #(.NUM_SLOTS(NUM_SLOTS)) u_pick_cur (
    .status (32'(status_cur)),
    .ctl    (slot_control),
    .hit    (hit_cur),
    .slot   (slot_cur)
  );

  // pick on post-write state for the hit flag
  vic_pick #(.NUM_SLOTS(NUM_SLOTS)) u_pick_next (
    .status (32'(status_next)),
    .ctl    (slot_control_next),
    .hit    (hit_next),
    .slot   (slot_next)
  );

  // one shared read port on the slot vector array
  assign rd_addr     = (item.word_index == OFS_VECTOR) ? slot_cur : slot_addr;
  assign rd_slot_vec = slot_vector[rd_addr];

  always_comb begin
    read_data = '0;
    if (is_read) begin
      case (item.word_index)
        OFS_STATUS: read_data = 32'(status_cur);
        OFS_ENSET:  read_data = 32'(enable_mask);
        OFS_VECTOR: read_data = hit_cur ? rd_slot_vec : default_vector;
        OFS_DEFVEC: read_data = default_vector;
        default: begin
          if (in_slot_vec) begin
            read_data = rd_slot_vec;
          end else if (in_slot_ctl) begin
            read_data = 32'(slot_control[slot_addr]);
          end
        end
      endcase
    end
  end

  // hit slot id is informational only; fold it into nothing but keep it visible
  assign irq_request = |status_next;
  assign vector_hit  = hit_next && (slot_next < SlotW'(NUM_SLOTS - 1) || 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= '0;
      default_vector <= '0;
      slot_control   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_vector[i] <= '0;
      end
    end else if (advance) begin
      enable_mask  <= enable_mask_next;
      slot_control <= slot_control_next;
      if (is_write && (item.word_index == OFS_DEFVEC)) begin
        default_vector <= item.write_data;
      end
      if (is_write && in_slot_vec) begin
        slot_vector[slot_addr] <= item.write_data;
      end
    end
  end

endmodule

FILE: hw/rtl/vectored_interrupt_controller.sv
// vectored_interrupt_controller: top level, request/response pipeline around vic_regs.
// Depends on vic_pkg, vic_regs (and through it vic_pick).
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries one bus item: a command
//   (sample, read or write), a word offset, write data and a sample of the 32
//   raw interrupt lines. Every item, even a plain sample, yields exactly one
//   response item on rsp_valid/rsp_ready/rsp: read data (zero unless a read of
//   a known register), irq_request (any enabled line pending) and vector_hit
//   (a slot matches), both taken after the item's own write.
//   Path: an accepted item waits in the input register until the result stage
//   is free or draining, then its response is registered and rsp_valid rises.
//   Throughput: one item per cycle unless rsp_ready stalls. The item sits in an
//   input register, the decode, slot pick and read mux are one combinational
//   pass into the response register, and state updates on that same edge so
//   the next item already sees it.
//   Stall: when rsp_ready is low with a response pending, the input register
//   holds its item and req_ready drops only if that register is occupied; no
//   item is lost or repeated.
//   Reset (rst, synchronous, active high): enable mask, default vector, slot
//   vectors and slot controls clear to zero; both pipeline stages empty.
module vectored_interrupt_controller import vic_pkg::*; #(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  vic_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output vic_out_t rsp
);

  // input stage
  logic    req_held;
  vic_in_t req_q;

  // result stage
  logic     rsp_full;
  vic_out_t rsp_q;

  logic        advance;
  logic [31:0] rd_data;
  logic        irq;
  logic        hit;

  // item leaves the input stage when the result stage is free or draining
  assign advance   = req_held && (!rsp_full || rsp_ready);
  assign req_ready = !req_held || advance;

  vic_regs #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_SOURCES (NUM_SOURCES)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (req_q),
    .read_data   (rd_data),
    .irq_request (irq),
    .vector_hit  (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_held <= 1'b0;
    end else if (req_valid && req_ready) begin
      req_held <= 1'b1;
    end else if (advance) begin
      req_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (advance) begin
      rsp_full <= 1'b1;
    end else if (rsp_ready) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q.read_data   <= rd_data;
      rsp_q.irq_request <= irq;
      rsp_q.vector_hit  <= hit;
    end
  end

  assign rsp_valid = rsp_full;
  assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/vic_checker.sv
// vic_checker: port-level assertions for the vectored interrupt controller.
// Depends on vic_pkg; bound onto vectored_interrupt_controller below.
module vic_checker import vic_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input vic_in_t  req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input vic_out_t rsp
);

  // a stalled response holds still
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // both stages empty right after a reset edge
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("pipeline not empty after reset");

  // an accepted item is followed by a valid response
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> ##1 rsp_valid)
    else $error("response missing after accepted item");

  // a slot can only match on a pending enabled source
  a_hit_implies_irq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !rsp.vector_hit || rsp.irq_request)
    else $error("vector hit without pending interrupt");

endmodule

bind vectored_interrupt_controller vic_checker u_vic_checker (.*);

FILE: tb/sv/vectored_interrupt_controller_tb.sv
// vectored_interrupt_controller_tb: self-checking bench for the vectored interrupt controller.
// Predicts every response from its own copy of the register state; depends on vic_pkg
// and the vectored_interrupt_controller RTL only.
module vectored_interrupt_controller_tb;
  import vic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = DEF_NUM_SLOTS;
  localparam int NUM_SOURCES = DEF_NUM_SOURCES;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // command code 3 is not in the package; the block treats it as sample only
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // source lines above NUM_SOURCES never reach status or the enable mask
  localparam logic [31:0] SRC_MASK = (NUM_SOURCES >= 32) ? '1 : ((32'd1 << NUM_SOURCES) - 1);
  localparam logic [31:0] CTL_ENABLE = 32'd1 << CTL_EN_BIT;

  localparam int RANDOM_PER_PHASE = 450;
  localparam int LONG_HOLD_CYCLES = 80;
  // longest legal quiet spell is the long hold-off plus a few idle cycles
  localparam int QUIET_LIMIT      = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  vic_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  vic_out_t rsp;

  vectored_interrupt_controller #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_SOURCES (NUM_SOURCES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow register state, updated in acceptance order. Everything resets to
  // zero and reset is applied once, so the declarations hold the reset values.
  // ---------------------------------------------------------------------------
  logic [31:0]       irq_enables     = '0;
  logic [31:0]       fallback_vector = '0;
  logic [31:0]       slot_addr [NUM_SLOTS];
  logic [CTL_W-1:0]  slot_ctrl [NUM_SLOTS];

  initial begin
    for (int n = 0; n < NUM_SLOTS; n++) begin
      slot_addr[n] = '0;
      slot_ctrl[n] = '0;
    end
  end

  vic_in_t  bus_requests [$];   // items waiting to be offered
  vic_out_t due_responses [$];  // predicted responses, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_offered     = 0;
  int rsp_count     = 0;
  int error_count   = 0;
  logic long_hold_tog = 1'b0;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic logic in_window(input logic [7:0] idx, input logic [7:0] base);
    return (idx >= base) && (int'(idx) < int'(base) + NUM_SLOTS);
  endfunction

  // Priority pick: lowest-numbered enabled slot whose source is pending.
  function automatic logic find_slot(input logic [31:0] status, output logic [SLOT_W-1:0] slot);
    logic found;
    found = 1'b0;
    slot  = '0;
    for (int n = 0; n < NUM_SLOTS; n++) begin
      if (!found && slot_ctrl[n][CTL_EN_BIT] && status[slot_ctrl[n][CTL_SRC_W-1:0]]) begin
        found = 1'b1;
        slot  = SLOT_W'(n);
      end
    end
    return found;
  endfunction

  // Read data uses the state before the item's write; irq_request and
  // vector_hit use the state after it.
  function automatic vic_out_t predict_response(input vic_in_t it);
    logic [31:0]       raw;
    logic [31:0]       status;
    logic [31:0]       rd;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] vec_idx;
    logic [SLOT_W-1:0] ctl_idx;
    vic_out_t          r;
    raw     = it.raw_sources & SRC_MASK;
    status  = raw & irq_enables;
    rd      = '0;
    vec_idx = SLOT_W'(it.word_index - OFS_SLOTVEC);
    ctl_idx = SLOT_W'(it.word_index - OFS_SLOTCTL);
    if (it.command == CMD_READ) begin
      if (it.word_index == OFS_STATUS) begin
        rd = status;
      end else if (it.word_index == OFS_ENSET) begin
        rd = irq_enables;
      end else if (it.word_index == OFS_VECTOR) begin
        if (find_slot(status, slot)) rd = slot_addr[slot];
        else rd = fallback_vector;
      end else if (it.word_index == OFS_DEFVEC) begin
        rd = fallback_vector;
      end else if (in_window(it.word_index, OFS_SLOTVEC)) begin
        rd = slot_addr[vec_idx];
      end else if (in_window(it.word_index, OFS_SLOTCTL)) begin
        rd = 32'(slot_ctrl[ctl_idx]);
      end
    end else if (it.command == CMD_WRITE) begin
      // status and vector writes fall through: ignored / acknowledge only
      if (it.word_index == OFS_ENSET) begin
        irq_enables = (irq_enables | it.write_data) & SRC_MASK;
      end else if (it.word_index == OFS_ENCLR) begin
        irq_enables = irq_enables & ~it.write_data;
      end else if (it.word_index == OFS_DEFVEC) begin
        fallback_vector = it.write_data;
      end else if (in_window(it.word_index, OFS_SLOTVEC)) begin
        slot_addr[vec_idx] = it.write_data;
      end else if (in_window(it.word_index, OFS_SLOTCTL)) begin
        slot_ctrl[ctl_idx] = it.write_data[CTL_W-1:0];
      end
    end
    status        = raw & irq_enables;
    r.read_data   = rd;
    r.irq_request = |status;
    r.vector_hit  = find_slot(status, slot);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic offer(input logic [1:0] cmd, input logic [7:0] idx,
                       input logic [31:0] data, input logic [31:0] raw);
    vic_in_t it;
    it.command     = cmd;
    it.word_index  = idx;
    it.write_data  = data;
    it.raw_sources = raw;
    bus_requests.push_back(it);
    n_offered++;
  endtask

  // Source samples: mostly sparse so that the slot priority decides the pick.
  function automatic logic [31:0] pick_sources();
    case ($urandom_range(6))
      0:       return $urandom;
      1:       return 32'd1 << $urandom_range(31);
      2:       return $urandom & $urandom;
      3:       return $urandom & $urandom & $urandom;
      4:       return (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
      5:       return '1;
      default: return '0;
    endcase
  endfunction

  task automatic queue_random(input int count);
    int          sel;
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic [31:0] data;
    logic [7:0]  slot;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 15)      cmd = CMD_SAMPLE;
      else if (sel < 50) cmd = CMD_READ;
      else if (sel < 95) cmd = CMD_WRITE;
      else               cmd = CMD_SPARE;
      slot = 8'($urandom_range(NUM_SLOTS - 1));
      sel  = $urandom_range(99);
      if (sel < 10)      idx = OFS_STATUS;
      else if (sel < 22) idx = OFS_ENSET;
      else if (sel < 30) idx = OFS_ENCLR;
      else if (sel < 48) idx = OFS_VECTOR;
      else if (sel < 54) idx = OFS_DEFVEC;
      else if (sel < 68) idx = OFS_SLOTVEC + slot;
      else if (sel < 86) idx = OFS_SLOTCTL + slot;
      else               idx = 8'($urandom_range(255));
      data = $urandom;
      // keep most slots enabled and most clears narrow, so picks stay busy
      if (in_window(idx, OFS_SLOTCTL) && $urandom_range(3) != 0) data[CTL_EN_BIT] = 1'b1;
      if (idx == OFS_ENCLR && $urandom_range(4) != 0) data = $urandom & $urandom & $urandom;
      offer(cmd, idx, data, pick_sources());
    end
  endtask

  // Sender stays quiet until every item offered so far has its response.
  task automatic wait_drained();
    while (rsp_count < n_offered) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: request channel. Valid holds with a stable payload until accepted;
  // the expected response is predicted at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        due_responses.push_back(predict_response(req));
      end
      if (!req_valid || req_ready) begin
        if (bus_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= bus_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: response channel. A toggle of long_hold_tog starts a long
  // hold-off, counted here, so the pipeline fills and req_ready drops.
  // ---------------------------------------------------------------------------
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin : rsp_side
    vic_out_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (due_responses.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with nothing outstanding", rsp_count));
        end else begin
          want = due_responses.pop_front();
          if (rsp.read_data !== want.read_data)
            report_mismatch($sformatf("response %0d read_data got %h want %h",
                                      rsp_count, rsp.read_data, want.read_data));
          if (rsp.irq_request !== want.irq_request)
            report_mismatch($sformatf("response %0d irq_request got %b want %b",
                                      rsp_count, rsp.irq_request, want.irq_request));
          if (rsp.vector_hit !== want.vector_hit)
            report_mismatch($sformatf("response %0d vector_hit got %b want %b",
                                      rsp_count, rsp.vector_hit, want.vector_hit));
        end
      end
      if (long_hold_tog != hold_seen) begin
        hold_seen = long_hold_tog;
        hold_left = LONG_HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any handshake on either channel means a hang.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, then three random phases with different
  // idle patterns. Each phase drains fully before the next one starts.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset state: nothing enabled, vector read falls back to zero
    offer(CMD_READ,  OFS_STATUS,         32'h0,          32'hFFFF_FFFF);
    offer(CMD_READ,  OFS_VECTOR,         32'h0,          32'hFFFF_FFFF);
    offer(CMD_READ,  OFS_SLOTCTL + 8'd15, 32'h0,         32'h0);
    // enable every source, then status mirrors the raw lines
    offer(CMD_WRITE, OFS_ENSET,          32'hFFFF_FFFF,  32'h0);
    offer(CMD_READ,  OFS_STATUS,         32'h0,          32'hFFFF_FFFF);
    offer(CMD_WRITE, OFS_DEFVEC,         32'hFFFF_FFFF,  32'h0);
    offer(CMD_READ,  OFS_DEFVEC,         32'h0,          32'h0);
    // last slot: all-ones vector, control write keeps only the low six bits
    offer(CMD_WRITE, OFS_SLOTVEC + 8'd15, 32'hFFFF_FFFF, 32'h0);
    offer(CMD_WRITE, OFS_SLOTCTL + 8'd15, 32'hFFFF_FFFF, 32'h0);
    offer(CMD_READ,  OFS_SLOTCTL + 8'd15, 32'h0,         32'h0);
    offer(CMD_READ,  OFS_VECTOR,         32'h0,          32'h8000_0000);
    // slot zero on source zero wins over slot fifteen when both pend
    offer(CMD_WRITE, OFS_SLOTVEC,        32'h0000_1000,  32'h0);
    offer(CMD_WRITE, OFS_SLOTCTL,        CTL_ENABLE,     32'h0);
    offer(CMD_READ,  OFS_VECTOR,         32'h0,          32'h8000_0001);
    offer(CMD_READ,  OFS_VECTOR,         32'h0,          32'h0);
    // vector write is only an acknowledge, status write is dropped
    offer(CMD_WRITE, OFS_VECTOR,         32'h5A5A_A5A5,  32'h1);
    offer(CMD_WRITE, OFS_STATUS,         32'h0,          32'hFFFF_FFFF);
    // command three behaves as a plain sample
    offer(CMD_SPARE, OFS_ENCLR,          32'hFFFF_FFFF,  32'hFFFF_FFFF);
    // offsets outside the map read zero and ignore writes
    offer(CMD_WRITE, 8'hFF,              32'h1234_5678,  32'h0);
    offer(CMD_READ,  8'hFF,              32'h0,          32'h0);
    offer(CMD_READ,  OFS_SLOTVEC + 8'(NUM_SLOTS), 32'h0, 32'h0);
    offer(CMD_READ,  OFS_SLOTCTL + 8'(NUM_SLOTS), 32'h0, 32'h0);
    // disabled slot naming source 31 must not match
    offer(CMD_WRITE, OFS_SLOTCTL + 8'd1, 32'h0000_001F,  32'h8000_0000);
    offer(CMD_WRITE, OFS_ENCLR,          32'h0000_0001,  32'h1);
    offer(CMD_READ,  OFS_ENSET,          32'h0,          32'h0);
    offer(CMD_SAMPLE, OFS_STATUS,        32'h0,          32'hFFFF_FFFF);
    offer(CMD_WRITE, OFS_ENCLR,          32'hFFFF_FFFF,  32'hFFFF_FFFF);
    offer(CMD_READ,  OFS_ENCLR,          32'h0,          32'hFFFF_FFFF);
    wait_drained();

    // sender sparse, receiver sparser
    send_idle_pct = 34;
    recv_idle_pct = 46;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    repeat ($urandom_range(3, 12)) @(posedge clk);

    // the other way round
    send_idle_pct = 46;
    recv_idle_pct = 34;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    repeat ($urandom_range(3, 12)) @(posedge clk);

    // back to back, with one long receiver hold-off while items keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    repeat (20) @(posedge clk);
    long_hold_tog = ~long_hold_tog;
    wait_drained();

    // a few spare cycles to catch any stray response
    repeat (6) @(posedge clk);
    if (due_responses.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", due_responses.size()));

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/vic_pkg.sv
hw/rtl/vic_pick.sv
hw/rtl/vic_regs.sv
hw/rtl/vectored_interrupt_controller.sv
hw/rtl/vic_checker.sv
tb/sv/vectored_interrupt_controller_tb.sv
